FILE: rtl/tatf_pkg.sv
// Shared types, constants and table functions for the thermistor temperature filter.
// No dependencies; used by all rtl/tatf_* modules and the top level.
`default_nettype none

package tatf_pkg;

  // Input sample width and table geometry
  localparam int ADC_BITS      = 12;
  localparam int CODE_W        = 12;
  localparam int TEMP_W        = 7;
  localparam int REP_W         = 9;
  localparam int TABLE_ROWS    = 16;
  localparam int ROW_W         = 4;
  localparam int STEP_W        = 6;
  localparam int SEGMENT_STEPS = 5;
  localparam logic [TEMP_W-1:0] HOT_LIMIT_TEMP = 7'd105;

  // Module parameter defaults
  localparam int SAMPLES_DEF = 10;
  localparam int TRIM_DEF    = 3;

  // Configuration port
  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;
  localparam int OFFS_W  = 8;
  localparam int SPIKE_W = 5;
  localparam logic [SPIKE_W-1:0] SPIKE_RST = 5'd5;

  typedef enum logic {
    REG_TEMP_OFFSET = 1'b0,
    REG_SPIKE_LIMIT = 1'b1
  } tatf_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_SUM,
    ST_DIV,
    ST_SEG,
    ST_FRAC,
    ST_POST
  } tatf_state_t;

  typedef struct packed {
    logic shift_in;   // push accepted sample into the batch
    logic sort_step;  // one odd/even compare-exchange pass
    logic sort_odd;   // pass parity
    logic acc_clr;    // clear accumulator
    logic sum_step;   // rotate batch, optionally accumulate head
    logic sum_take;   // head lies inside the kept window
    logic div_step;   // replace the sum by its quotient
    logic seg_load;   // latch average and segment index
    logic frac_load;  // latch table temperature
    logic post_load;  // spike filter, peak, offset; load outputs
  } tatf_cmd_t;

  // Table codes fall as the temperature rises
  function automatic logic [CODE_W-1:0] row_code(input logic [ROW_W-1:0] idx);
    logic [CODE_W-1:0] c;
    unique case (idx)
      4'd0:    c = 12'd2786;
      4'd1:    c = 12'd2615;
      4'd2:    c = 12'd2440;
      4'd3:    c = 12'd2263;
      4'd4:    c = 12'd2088;
      4'd5:    c = 12'd1918;
      4'd6:    c = 12'd1753;
      4'd7:    c = 12'd1597;
      4'd8:    c = 12'd1450;
      4'd9:    c = 12'd1311;
      4'd10:   c = 12'd1187;
      4'd11:   c = 12'd1071;
      4'd12:   c = 12'd966;
      4'd13:   c = 12'd871;
      4'd14:   c = 12'd786;
      default: c = 12'd709;
    endcase
    return c;
  endfunction

  function automatic logic [TEMP_W-1:0] row_temp(input logic [ROW_W-1:0] idx);
    return TEMP_W'(7'd25 + 7'd5 * TEMP_W'(idx));
  endfunction

  // Fifth of the code span of the segment ending at row idx (row 0 has none)
  function automatic logic [STEP_W-1:0] seg_step(input logic [ROW_W-1:0] idx);
    logic [STEP_W-1:0] s;
    unique case (idx)
      4'd1:    s = 6'd34;
      4'd2:    s = 6'd35;
      4'd3:    s = 6'd35;
      4'd4:    s = 6'd35;
      4'd5:    s = 6'd34;
      4'd6:    s = 6'd33;
      4'd7:    s = 6'd31;
      4'd8:    s = 6'd29;
      4'd9:    s = 6'd27;
      4'd10:   s = 6'd24;
      4'd11:   s = 6'd23;
      4'd12:   s = 6'd21;
      4'd13:   s = 6'd19;
      4'd14:   s = 6'd17;
      4'd15:   s = 6'd15;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/adc_thermistor_temperature_filter.sv
// Top level of the thermistor temperature filter: configuration registers,
// controller and datapath. Depends on tatf_pkg, tatf_regs, tatf_ctrl, tatf_dp.
//
// Usage:
//   Input channel (in_valid/in_ready/in_adc_sample) takes raw ADC samples. Each
//   transfer that does not complete a batch produces no result.
//   The SAMPLES-th transfer of a batch starts processing: odd/even sort passes,
//   trimmed accumulation, a reciprocal-multiply divide, then segment search,
//   interpolation and result load. in_ready is low during processing.
//   Output channel (out_valid/out_ready) holds one result in a register; new
//   samples are taken while it waits. If a batch finishes while the previous
//   result is still held, the block waits before loading it.
//   APB-style port: temp_offset at 0x0, spike_limit at 0x4; pready is always high.
//   Reset (rst_n low, synchronous) empties the batch, clears the previous and peak
//   temperatures, drops any pending result and returns the registers to defaults.
`default_nettype none

module adc_thermistor_temperature_filter #(
  parameter int SAMPLES = tatf_pkg::SAMPLES_DEF,
  parameter int TRIM    = tatf_pkg::TRIM_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [tatf_pkg::ADC_BITS-1:0]         in_adc_sample,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [tatf_pkg::REP_W-1:0]          out_reported_temp,
  output logic [tatf_pkg::TEMP_W-1:0]                out_filtered_temp,
  output logic [tatf_pkg::TEMP_W-1:0]                out_peak_temp_out,
  output logic [tatf_pkg::ADC_BITS-1:0]              out_averaged_adc,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [tatf_pkg::ADDR_W-1:0]           paddr,
  input  wire logic [tatf_pkg::PDATA_W-1:0]          pwdata,
  output logic [tatf_pkg::PDATA_W-1:0]               prdata,
  output logic                                       pready
);

  tatf_pkg::tatf_cmd_t                 cmd;
  logic signed [tatf_pkg::OFFS_W-1:0]  temp_offset;
  logic [tatf_pkg::SPIKE_W-1:0]        spike_limit;

  tatf_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .temp_offset (temp_offset),
    .spike_limit (spike_limit)
  );

  tatf_ctrl #(
    .SAMPLES (SAMPLES),
    .TRIM    (TRIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tatf_dp #(
    .SAMPLES (SAMPLES),
    .TRIM    (TRIM)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_sample     (in_adc_sample),
    .temp_offset   (temp_offset),
    .spike_limit   (spike_limit),
    .reported_temp (out_reported_temp),
    .filtered_temp (out_filtered_temp),
    .peak_temp_out (out_peak_temp_out),
    .averaged_adc  (out_averaged_adc)
  );

endmodule

`default_nettype wire

FILE: rtl/tatf_regs.sv
// Configuration registers (temp_offset, spike_limit) behind the APB-style port.
// Depends on tatf_pkg.
`default_nettype none

module tatf_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tatf_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [tatf_pkg::PDATA_W-1:0]       pwdata,
  output logic      [tatf_pkg::PDATA_W-1:0]       prdata,
  output logic                                    pready,
  output logic signed [tatf_pkg::OFFS_W-1:0]      temp_offset,
  output logic      [tatf_pkg::SPIKE_W-1:0]       spike_limit
);

  logic signed [tatf_pkg::OFFS_W-1:0]  offset_r, offset_nxt;
  logic        [tatf_pkg::SPIKE_W-1:0] spike_r, spike_nxt;
  logic                                wr_en;
  tatf_pkg::tatf_reg_t                 reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = tatf_pkg::tatf_reg_t'(paddr[2]);

  always_comb begin
    offset_nxt = offset_r;
    spike_nxt  = spike_r;
    if (wr_en) begin
      unique case (reg_sel)
        tatf_pkg::REG_TEMP_OFFSET: offset_nxt = pwdata[tatf_pkg::OFFS_W-1:0];
        tatf_pkg::REG_SPIKE_LIMIT: spike_nxt  = pwdata[tatf_pkg::SPIKE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      spike_r  <= tatf_pkg::SPIKE_RST;
    end else begin
      offset_r <= offset_nxt;
      spike_r  <= spike_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      tatf_pkg::REG_TEMP_OFFSET:
        prdata = {{(tatf_pkg::PDATA_W-tatf_pkg::OFFS_W){1'b0}}, offset_r};
      tatf_pkg::REG_SPIKE_LIMIT:
        prdata = {{(tatf_pkg::PDATA_W-tatf_pkg::SPIKE_W){1'b0}}, spike_r};
      default: prdata = '0;
    endcase
  end

  assign temp_offset = offset_r;
  assign spike_limit = spike_r;

endmodule

`default_nettype wire

FILE: rtl/tatf_ctrl.sv
// Controller: batch counter, phase counter and the state machine that sequences
// sort, trimmed sum, divide, table lookup and result output. Depends on tatf_pkg.
`default_nettype none

module tatf_ctrl #(
  parameter int SAMPLES = tatf_pkg::SAMPLES_DEF,
  parameter int TRIM    = tatf_pkg::TRIM_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tatf_pkg::tatf_cmd_t cmd
);

  localparam int TRIM_E = (2 * TRIM >= SAMPLES) ? (SAMPLES - 1) / 2 : TRIM;
  localparam int CNT_W  = $clog2(SAMPLES + 1);
  localparam int SC_W   = $clog2(SAMPLES);

  tatf_pkg::tatf_state_t state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SC_W-1:0]       scnt_r, scnt_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tatf_pkg::ST_IDLE;
      cnt_r       <= '0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      scnt_r      <= scnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    scnt_nxt      = scnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      tatf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.shift_in = 1'b1;
          if (scnt_r == SC_W'(SAMPLES - 1)) begin
            scnt_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = tatf_pkg::ST_SORT;
          end else begin
            scnt_nxt = scnt_r + SC_W'(1);
          end
        end
      end
      tatf_pkg::ST_SORT: begin
        cmd.sort_step = 1'b1;
        cmd.sort_odd  = cnt_r[0];
        if (cnt_r == CNT_W'(SAMPLES - 1)) begin
          cnt_nxt     = '0;
          cmd.acc_clr = 1'b1;
          state_nxt   = tatf_pkg::ST_SUM;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      tatf_pkg::ST_SUM: begin
        // keep only the sorted positions between the two trimmed ends
        cmd.sum_step = 1'b1;
        cmd.sum_take = (cnt_r >= CNT_W'(TRIM_E)) && (cnt_r < CNT_W'(SAMPLES - TRIM_E));
        if (cnt_r == CNT_W'(SAMPLES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tatf_pkg::ST_DIV;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      tatf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = tatf_pkg::ST_SEG;
      end
      tatf_pkg::ST_SEG: begin
        cmd.seg_load = 1'b1;
        state_nxt    = tatf_pkg::ST_FRAC;
      end
      tatf_pkg::ST_FRAC: begin
        cmd.frac_load = 1'b1;
        state_nxt     = tatf_pkg::ST_POST;
      end
      tatf_pkg::ST_POST: begin
        // hold until the previous result has been taken
        if (!out_valid_r || out_ready) begin
          cmd.post_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = tatf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tatf_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/tatf_dp.sv
// Datapath: sample batch with odd/even transposition sort, trimmed accumulator,
// reciprocal divider, table conversion, spike filter, peak and offset. Depends on tatf_pkg.
`default_nettype none

module tatf_dp #(
  parameter int SAMPLES = tatf_pkg::SAMPLES_DEF,
  parameter int TRIM    = tatf_pkg::TRIM_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire tatf_pkg::tatf_cmd_t                  cmd,
  input  wire logic [tatf_pkg::ADC_BITS-1:0]        in_sample,
  input  wire logic signed [tatf_pkg::OFFS_W-1:0]   temp_offset,
  input  wire logic [tatf_pkg::SPIKE_W-1:0]         spike_limit,
  output logic signed [tatf_pkg::REP_W-1:0]         reported_temp,
  output logic [tatf_pkg::TEMP_W-1:0]               filtered_temp,
  output logic [tatf_pkg::TEMP_W-1:0]               peak_temp_out,
  output logic [tatf_pkg::ADC_BITS-1:0]             averaged_adc
);

  localparam int AW      = tatf_pkg::ADC_BITS;
  localparam int TW      = tatf_pkg::TEMP_W;
  localparam int CW      = tatf_pkg::CODE_W;
  localparam int RW      = tatf_pkg::ROW_W;
  localparam int TRIM_E  = (2 * TRIM >= SAMPLES) ? (SAMPLES - 1) / 2 : TRIM;
  localparam int KEEP    = SAMPLES - 2 * TRIM_E;
  localparam int SUM_W   = AW + $clog2(SAMPLES);
  localparam int KEEP_LG = $clog2(KEEP);
  localparam int DIV_SH  = SUM_W + KEEP_LG;
  localparam int RCP_W   = SUM_W + 2;
  localparam int PROD_W  = SUM_W + RCP_W;
  // rounded-up reciprocal of the kept count: floor quotient is exact below 2**SUM_W
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << DIV_SH) + 64'(KEEP) - 64'd1) / 64'(KEEP));

  // ---------------- batch store, sort, rotate ----------------
  logic [AW-1:0] smp_r   [SAMPLES];
  logic [AW-1:0] smp_nxt [SAMPLES];

  always_comb begin
    smp_nxt = smp_r;
    if (cmd.shift_in) begin
      for (int k = 0; k < SAMPLES - 1; k++) smp_nxt[k] = smp_r[k+1];
      smp_nxt[SAMPLES-1] = in_sample;
    end else if (cmd.sort_step) begin
      // pairs of one parity are disjoint: exchange each out-of-order pair
      for (int k = 0; k < SAMPLES - 1; k++) begin
        if ((1'(k & 1) == cmd.sort_odd) && (smp_r[k] > smp_r[k+1])) begin
          smp_nxt[k]   = smp_r[k+1];
          smp_nxt[k+1] = smp_r[k];
        end
      end
    end else if (cmd.sum_step) begin
      for (int k = 0; k < SAMPLES - 1; k++) smp_nxt[k] = smp_r[k+1];
      smp_nxt[SAMPLES-1] = smp_r[0];
    end
  end

  always_ff @(posedge clk) begin
    smp_r <= smp_nxt;
  end

  // ---------------- accumulator and divider ----------------
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(acc_r) * PROD_W'(RCP);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_clr) begin
      acc_nxt = '0;
    end else if (cmd.sum_step) begin
      if (cmd.sum_take) acc_nxt = acc_r + SUM_W'(smp_r[0]);
    end else if (cmd.div_step) begin
      acc_nxt = SUM_W'(prod[DIV_SH +: AW]);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // ---------------- table segment search ----------------
  logic [AW-1:0] avg_r;
  logic [RW-1:0] seg_r;
  logic          hot_r;
  logic [AW-1:0] avg_in;
  logic [RW-1:0] seg_c;
  logic          hot_c;

  assign avg_in = acc_r[AW-1:0];

  always_comb begin
    hot_c = 1'b1;
    seg_c = RW'(1);
    // lowest row whose code lies below the reading wins
    for (int i = tatf_pkg::TABLE_ROWS - 1; i >= 1; i--) begin
      if (avg_in > tatf_pkg::row_code(RW'(i))) begin
        hot_c = 1'b0;
        seg_c = RW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      avg_r <= avg_in;
      seg_r <= seg_c;
      hot_r <= hot_c;
    end
  end

  // ---------------- fifth-step interpolation ----------------
  logic [TW-1:0] temp_r;
  logic [TW-1:0] temp_c;

  always_comb begin
    logic [CW-1:0]               hi;
    logic [CW-1:0]               lo;
    logic [CW-1:0]               n;
    logic [tatf_pkg::STEP_W-1:0] stp;
    logic [TW-1:0]               t;
    logic [TW-1:0]               t_top;
    logic                        go;
    hi    = tatf_pkg::row_code(seg_r - RW'(1));
    lo    = tatf_pkg::row_code(seg_r);
    stp   = tatf_pkg::seg_step(seg_r);
    t     = tatf_pkg::row_temp(seg_r - RW'(1));
    t_top = tatf_pkg::row_temp(seg_r);
    go    = (stp != '0);
    for (int k = 1; k <= tatf_pkg::SEGMENT_STEPS; k++) begin
      n  = hi - CW'(stp) * CW'(k);
      go = go && (n > lo) && (CW'(avg_r) <= n);
      if (go) t = t + TW'(1);
    end
    if (t > t_top) t = t_top;
    temp_c = hot_r ? tatf_pkg::HOT_LIMIT_TEMP : t;
  end

  always_ff @(posedge clk) begin
    if (cmd.frac_load) temp_r <= temp_c;
  end

  // ---------------- spike filter, peak, offset ----------------
  logic [TW-1:0] prev_r, prev_nxt;
  logic [TW-1:0] peak_r, peak_nxt;
  logic [TW-1:0] diff;
  logic          reject;
  logic [TW-1:0] t_flt;
  logic signed [tatf_pkg::REP_W-1:0] rep_c;

  assign diff   = (temp_r >= prev_r) ? temp_r - prev_r : prev_r - temp_r;
  assign reject = (prev_r != '0) && (diff >= TW'(spike_limit));
  assign t_flt  = reject ? prev_r : temp_r;
  assign rep_c  = $signed({2'b00, t_flt})
                - $signed({temp_offset[tatf_pkg::OFFS_W-1], temp_offset});

  always_comb begin
    prev_nxt = prev_r;
    peak_nxt = peak_r;
    if (cmd.post_load) begin
      prev_nxt = t_flt;
      if (t_flt > peak_r) peak_nxt = t_flt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      peak_r <= '0;
    end else begin
      prev_r <= prev_nxt;
      peak_r <= peak_nxt;
    end
  end

  logic signed [tatf_pkg::REP_W-1:0] rep_r;
  logic [TW-1:0]                     flt_r;
  logic [TW-1:0]                     pk_out_r;
  logic [AW-1:0]                     avg_out_r;

  always_ff @(posedge clk) begin
    if (cmd.post_load) begin
      rep_r     <= rep_c;
      flt_r     <= t_flt;
      pk_out_r  <= peak_nxt;
      avg_out_r <= avg_r;
    end
  end

  assign reported_temp = rep_r;
  assign filtered_temp = flt_r;
  assign peak_temp_out = pk_out_r;
  assign averaged_adc  = avg_out_r;

endmodule

`default_nettype wire

FILE: verif/tb_adc_thermistor_temperature_filter.sv
// Self-checking testbench for adc_thermistor_temperature_filter: random and directed
// ADC batches, APB register settings, a temperature predictor and a result scoreboard.
// Depends on tatf_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_adc_thermistor_temperature_filter;

  localparam int BATCH         = tatf_pkg::SAMPLES_DEF;
  localparam int KEEP_TRIM     = tatf_pkg::TRIM_DEF;
  localparam int ROWS          = tatf_pkg::TABLE_ROWS;
  localparam int SETTLE_CYCLES = 60;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASES        = 6;
  localparam int PHASE_BATCHES = 30;

  // Divider codes of the conversion table, hottest row last
  localparam int unsigned CODE_TAB[ROWS] = '{
    2786, 2615, 2440, 2263, 2088, 1918, 1753, 1597,
    1450, 1311, 1187, 1071, 966, 871, 786, 709
  };

  typedef struct packed {
    logic signed [tatf_pkg::REP_W-1:0] reported;
    logic [tatf_pkg::TEMP_W-1:0]       filtered;
    logic [tatf_pkg::TEMP_W-1:0]       peak;
    logic [tatf_pkg::ADC_BITS-1:0]     average;
  } temp_reading_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [tatf_pkg::ADC_BITS-1:0]       in_adc_sample = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [tatf_pkg::REP_W-1:0]   out_reported_temp;
  logic [tatf_pkg::TEMP_W-1:0]         out_filtered_temp;
  logic [tatf_pkg::TEMP_W-1:0]         out_peak_temp_out;
  logic [tatf_pkg::ADC_BITS-1:0]       out_averaged_adc;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [tatf_pkg::ADDR_W-1:0]         paddr = '0;
  logic [tatf_pkg::PDATA_W-1:0]        pwdata = '0;
  logic [tatf_pkg::PDATA_W-1:0]        prdata;
  logic                                pready;

  adc_thermistor_temperature_filter u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_adc_sample     (in_adc_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reported_temp (out_reported_temp),
    .out_filtered_temp (out_filtered_temp),
    .out_peak_temp_out (out_peak_temp_out),
    .out_averaged_adc  (out_averaged_adc),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Predictor state
  int unsigned       batch_codes[BATCH];
  int unsigned       batch_fill = 0;
  int unsigned       last_temp = 0;
  int unsigned       peak_seen = 0;
  logic signed [7:0] offset_cfg = 8'sd0;
  logic [4:0]        spike_cfg = tatf_pkg::SPIKE_RST;

  logic [tatf_pkg::ADC_BITS-1:0] pending_codes[$];
  temp_reading_t                 expected_readings[$];

  logic in_fired = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   quiet_cycles = 0;
  int   error_count = 0;
  int   samples_taken = 0;
  int   readings_checked = 0;
  int   walk_center = 2800;

  initial begin
    forever #5 clk = ~clk;
  end

  // Collect one sample; on a full batch work out the reading it produces
  task automatic take_sample(input logic [tatf_pkg::ADC_BITS-1:0] code);
    int unsigned   sorted[BATCH];
    int unsigned   v, k, sum, avg, seg, hi, lo, step, deg, diff;
    int            rep;
    temp_reading_t r;
    batch_codes[batch_fill] = code;
    batch_fill++;
    if (batch_fill < BATCH) return;
    batch_fill = 0;

    for (int i = 0; i < BATCH; i++) begin
      v = batch_codes[i];
      k = i;
      while (k > 0 && sorted[k-1] > v) begin
        sorted[k] = sorted[k-1];
        k--;
      end
      sorted[k] = v;
    end
    sum = 0;
    for (int i = KEEP_TRIM; i < BATCH - KEEP_TRIM; i++) sum += sorted[i];
    avg = sum / (BATCH - 2 * KEEP_TRIM);

    // Find the segment, then count whole fifths of its span
    seg = 1;
    while (seg < ROWS && avg <= CODE_TAB[seg]) seg++;
    if (seg == ROWS) begin
      deg = tatf_pkg::HOT_LIMIT_TEMP;
    end else begin
      hi   = CODE_TAB[seg-1];
      lo   = CODE_TAB[seg];
      step = (hi - lo) / tatf_pkg::SEGMENT_STEPS;
      deg  = 25 + 5 * (seg - 1);
      k    = 1;
      while (step != 0 && k <= tatf_pkg::SEGMENT_STEPS && hi - k * step > lo
             && avg <= hi - k * step) begin
        deg++;
        k++;
      end
      if (deg > 25 + 5 * seg) deg = 25 + 5 * seg;
    end

    // Hold the previous reading on a spike
    if (last_temp != 0) begin
      diff = (deg >= last_temp) ? deg - last_temp : last_temp - deg;
      if (diff >= spike_cfg) deg = last_temp;
      else last_temp = deg;
    end else begin
      last_temp = deg;
    end
    if (deg > peak_seen) peak_seen = deg;

    rep        = int'(deg) - int'(offset_cfg);
    r.reported = rep[tatf_pkg::REP_W-1:0];
    r.filtered = deg[tatf_pkg::TEMP_W-1:0];
    r.peak     = peak_seen[tatf_pkg::TEMP_W-1:0];
    r.average  = avg[tatf_pkg::ADC_BITS-1:0];
    expected_readings.push_back(r);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Input driver and ready generator: change at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fired) begin
        if (pending_codes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid      <= 1'b1;
          in_adc_sample <= pending_codes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    temp_reading_t want;
    in_fired <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        take_sample(in_adc_sample);
        samples_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          error_count++;
          $display("%0t: unexpected reading, expected none, actual reported %0d filtered %0d",
                   $time, out_reported_temp, out_filtered_temp);
        end else begin
          want = expected_readings.pop_front();
          check_field("reported_temp", want.reported, out_reported_temp);
          check_field("filtered_temp", want.filtered, out_filtered_temp);
          check_field("peak_temp_out", want.peak, out_peak_temp_out);
          check_field("averaged_adc", want.average, out_averaged_adc);
          readings_checked++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
          $display("tb_adc_thermistor_temperature_filter failed");
          $finish;
        end
      end
    end
  end

  // APB write with setup and access phases; mirror the register in the predictor
  task automatic write_reg(input tatf_pkg::tatf_reg_t idx,
                           input logic [tatf_pkg::PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      tatf_pkg::REG_TEMP_OFFSET: offset_cfg = value[7:0];
      tatf_pkg::REG_SPIKE_LIMIT: spike_cfg  = value[4:0];
    endcase
  endtask

  // Hold off until every sample is in, every reading is out and the block has settled
  task automatic drain_block();
    while (pending_codes.size() != 0 || in_valid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly a slow random walk of the divider code so readings pass the spike filter,
  // with occasional jumps, outliers for the trim and pure noise batches
  task automatic queue_batch();
    int pick, spread, s;
    pick = $urandom_range(99);
    if (pick < 70) walk_center += int'($urandom_range(80)) - 40;
    else if (pick < 85) walk_center = $urandom_range(2950, 550);
    if (walk_center < 550) walk_center = 550;
    if (walk_center > 2950) walk_center = 2950;
    spread = $urandom_range(24);
    for (int i = 0; i < BATCH; i++) begin
      if (pick >= 85) s = $urandom_range(4095);
      else if ($urandom_range(9) == 0) s = $urandom_range(1) ? 4095 : 0;
      else s = walk_center + int'($urandom_range(2 * spread)) - spread;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      pending_codes.push_back(s[tatf_pkg::ADC_BITS-1:0]);
    end
  endtask

  initial begin
    int phase_offset[PHASES];
    int phase_spike[PHASES];
    phase_offset = '{0, -128, 127, -1, 0, 25};
    phase_spike  = '{5, 31, 1, 0, 0, 20};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: first reading from a cold batch, then a hot batch rejected as a spike
    write_reg(tatf_pkg::REG_TEMP_OFFSET, 32'd127);
    write_reg(tatf_pkg::REG_SPIKE_LIMIT, 32'd31);
    repeat (BATCH) pending_codes.push_back('1);
    repeat (BATCH) pending_codes.push_back('0);
    drain_block();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 4) begin
        phase_offset[p] = $urandom_range(255);
        phase_spike[p]  = $urandom_range(31, 1);
      end
      write_reg(tatf_pkg::REG_TEMP_OFFSET, tatf_pkg::PDATA_W'(phase_offset[p]));
      write_reg(tatf_pkg::REG_SPIKE_LIMIT, tatf_pkg::PDATA_W'(phase_spike[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      repeat (PHASE_BATCHES) queue_batch();
      drain_block();
    end

    $display("Ran %0d ADC samples, checked %0d readings; offsets -128..127, spike limits 0..31,",
             samples_taken, readings_checked);
    $display("with sender gaps, receiver stalls, trimmed outliers and both ends of the table.");
    if (error_count == 0 && expected_readings.size() == 0) begin
      $display("tb_adc_thermistor_temperature_filter passed");
    end else begin
      $display("tb_adc_thermistor_temperature_filter failed");
    end
    $finish;
  end

endmodule
